// ----- src/memory_segment_table_lookup_top_assert.svh -----
// Assertion macros for the memory segment table lookup block.
// Included by the modules that carry assertions; no other dependencies.
`ifndef MEMORY_SEGMENT_TABLE_LOOKUP_TOP_ASSERT_SVH
`define MEMORY_SEGMENT_TABLE_LOOKUP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MSTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mstl assertion failed");
// next-cycle implication
`define MSTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mstl assertion failed");
`else
`define MSTL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSTL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/mstl_pkg.sv -----
// Shared types, codes and sizes of the memory segment table lookup block.
// No dependencies; imported by every module of the block.
package mstl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int FUNC_W = 2;
	localparam int SLOT_W = 3;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;
	localparam int COUNT_W = 16;
	localparam int INDEX_W = 16;
	localparam int STATUS_W = 2;

	// quotient of a region lookup always fits the index width
	localparam int DIV_STEPS = INDEX_W;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS);

	// configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int EIU_W = 4;
	localparam int REG_ENTRIES_IN_USE = 0;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADDR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INDEX = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] entry_slot;
		logic [ADDR_W-1:0] entry_start;
		logic [SIZE_W-1:0] entry_segment_size;
		logic [COUNT_W-1:0] entry_segment_count;
		logic [ADDR_W-1:0] query_address;
		logic [INDEX_W-1:0] wanted_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0] segment_address;
		logic [SIZE_W-1:0] segment_size;
		logic [INDEX_W-1:0] segment_index;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] seg_size;
		logic [COUNT_W-1:0] seg_count;
	} entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		entry_t entry;
	} tbl_wr_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_MULADD,
		ALU_DIV_LOAD,
		ALU_DIV_STEP
	} alu_op_t;

	// muladd: addend + mcand * mplier; div load: dividend in addend;
	// div step: divisor in mcand
	typedef struct packed {
		alu_op_t op;
		logic [ADDR_W-1:0] addend;
		logic [SIZE_W-1:0] mcand;
		logic [INDEX_W-1:0] mplier;
	} alu_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] res;
		logic [INDEX_W-1:0] quo;
	} alu_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_BOUND,
		ST_CHECK,
		ST_DIVIDE,
		ST_LOCATE,
		ST_FINISH
	} ctrl_state_t;

endpackage

// ----- src/mstl_table.sv -----
// Region table storage: one write port and one registered read port.
// Depends on mstl_pkg.
module mstl_table import mstl_pkg::*; (
	input logic clk,
	input tbl_wr_t wr,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_addr,
	output entry_t rd_entry
);

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

// ----- src/mstl_alu.sv -----
// Shared arithmetic unit: 32x16 multiply-add and restoring divide steps.
// Depends on mstl_pkg.
module mstl_alu import mstl_pkg::*; (
	input logic clk,
	input alu_cmd_t cmd,
	output alu_out_t result
);

	logic [ADDR_W-1:0] res_q;
	logic [SIZE_W-1:0] rem_q;
	logic [INDEX_W-1:0] dvd_q;
	logic [INDEX_W-1:0] quo_q;

	logic [SIZE_W+INDEX_W-1:0] prod;
	logic [SIZE_W:0] part;
	logic [SIZE_W:0] diff;
	logic ge;

	// product and one division step
	always_comb begin
		prod = (SIZE_W + INDEX_W)'(cmd.mcand) * (SIZE_W + INDEX_W)'(cmd.mplier);
		part = {rem_q, dvd_q[INDEX_W-1]};
		ge = part >= {1'b0, cmd.mcand};
		diff = part - {1'b0, cmd.mcand};
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ALU_MULADD: begin
				res_q <= cmd.addend + prod[ADDR_W-1:0];
			end
			ALU_DIV_LOAD: begin
				rem_q <= SIZE_W'(cmd.addend[ADDR_W-1:INDEX_W]);
				dvd_q <= cmd.addend[INDEX_W-1:0];
				quo_q <= '0;
			end
			ALU_DIV_STEP: begin
				rem_q <= ge ? diff[SIZE_W-1:0] : part[SIZE_W-1:0];
				dvd_q <= {dvd_q[INDEX_W-2:0], 1'b0};
				quo_q <= {quo_q[INDEX_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign result.res = res_q;
	assign result.quo = quo_q;

endmodule

// ----- src/mstl_ctrl.sv -----
// Sequencer of the lookup block: table walk, divide control and output register.
// Depends on mstl_pkg and memory_segment_table_lookup_top_assert.svh.
`include "memory_segment_table_lookup_top_assert.svh"

module mstl_ctrl import mstl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [EIU_W-1:0] entries_in_use,
	input logic req_valid,
	output logic req_stall,
	input req_t req_item,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp_item,
	output tbl_wr_t tbl_wr,
	output logic tbl_rd_en,
	output logic [IDX_W-1:0] tbl_rd_addr,
	input entry_t tbl_rd_entry,
	output alu_cmd_t alu_cmd,
	input alu_out_t alu_out
);

	ctrl_state_t state_q, state_d;
	req_t req_q;
	logic [CNT_W-1:0] idx_q;
	logic [INDEX_W-1:0] base_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic found_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic req_accept;
	logic [CNT_W-1:0] walk_len;
	logic [CNT_W-1:0] idx_next;
	logic walk_last;
	logic addr_hit;
	logic index_hit;
	logic walk_adv;
	logic hit_set;
	logic rsp_load;
	rsp_t rsp_d;

	// walk length clipped to the table size
	always_comb begin
		if (32'(entries_in_use) > TABLE_ENTRIES) begin
			walk_len = CNT_W'(TABLE_ENTRIES);
		end else begin
			walk_len = CNT_W'(entries_in_use);
		end
	end

	assign req_accept = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign idx_next = idx_q + CNT_W'(1);
	assign walk_last = (idx_next == walk_len);
	assign tbl_rd_addr = idx_q[IDX_W-1:0];

	// region membership and index range tests
	always_comb begin
		addr_hit = (req_q.query_address >= tbl_rd_entry.start)
			&& (req_q.query_address < alu_out.res)
			&& (tbl_rd_entry.seg_size != '0);
		index_hit = {1'b0, req_q.wanted_index}
			< ({1'b0, base_q} + {1'b0, tbl_rd_entry.seg_count});
	end

	// table write straight from the accepted transfer
	always_comb begin
		tbl_wr.en = req_accept && (req_item.func == FUNC_WRITE)
			&& (32'(req_item.entry_slot) < TABLE_ENTRIES);
		tbl_wr.addr = IDX_W'(req_item.entry_slot);
		tbl_wr.entry.start = req_item.entry_start;
		tbl_wr.entry.seg_size = req_item.entry_segment_size;
		tbl_wr.entry.seg_count = req_item.entry_segment_count;
	end

	// next state and unit commands
	always_comb begin
		state_d = state_q;
		tbl_rd_en = 1'b0;
		walk_adv = 1'b0;
		hit_set = 1'b0;
		rsp_load = 1'b0;
		alu_cmd.op = ALU_IDLE;
		alu_cmd.addend = tbl_rd_entry.start;
		alu_cmd.mcand = tbl_rd_entry.seg_size;
		alu_cmd.mplier = tbl_rd_entry.seg_count;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					priority if (req_item.func == FUNC_WRITE) begin
						state_d = ST_FINISH;
					end else if ((req_item.func == FUNC_ADDR || req_item.func == FUNC_INDEX)
						&& walk_len != '0) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FETCH: begin
				tbl_rd_en = 1'b1;
				state_d = ST_BOUND;
			end
			ST_BOUND: begin
				alu_cmd.op = ALU_MULADD;
				if (req_q.func == FUNC_ADDR) begin
					// region end
					state_d = ST_CHECK;
				end else begin
					// segment address for the index offset
					alu_cmd.mplier = req_q.wanted_index - base_q;
					if (index_hit) begin
						hit_set = 1'b1;
						state_d = ST_FINISH;
					end else begin
						walk_adv = 1'b1;
						state_d = walk_last ? ST_FINISH : ST_FETCH;
					end
				end
			end
			ST_CHECK: begin
				alu_cmd.op = ALU_DIV_LOAD;
				alu_cmd.addend = req_q.query_address - tbl_rd_entry.start;
				if (addr_hit) begin
					hit_set = 1'b1;
					state_d = ST_DIVIDE;
				end else begin
					walk_adv = 1'b1;
					state_d = walk_last ? ST_FINISH : ST_FETCH;
				end
			end
			ST_DIVIDE: begin
				alu_cmd.op = ALU_DIV_STEP;
				if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				alu_cmd.op = ALU_MULADD;
				alu_cmd.mplier = alu_out.quo;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result fields
	always_comb begin
		rsp_d = '0;
		priority if (req_q.func == FUNC_WRITE) begin
			rsp_d.status = STATUS_WRITTEN;
		end else if (found_q) begin
			rsp_d.status = STATUS_FOUND;
			rsp_d.segment_address = alu_out.res;
			rsp_d.segment_size = tbl_rd_entry.seg_size;
			if (req_q.func == FUNC_ADDR) begin
				rsp_d.segment_index = base_q + alu_out.quo;
			end
		end else begin
			rsp_d.status = STATUS_NOT_FOUND;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			base_q <= '0;
			step_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (req_accept) begin
				idx_q <= '0;
				base_q <= '0;
				step_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (walk_adv) begin
					idx_q <= idx_next;
					base_q <= base_q + tbl_rd_entry.seg_count;
				end
				if (hit_set) begin
					found_q <= 1'b1;
				end
				if (state_q == ST_DIVIDE) begin
					step_q <= step_q + DIV_STEP_W'(1);
				end
			end
		end
	end

	// captured request
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req_item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_q;

	// divider never runs on an empty region
	`MSTL_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == ST_DIVIDE, tbl_rd_entry.seg_size != '0)
	// walk stays inside the entries in use
	`MSTL_ASSERT_IMP(a_walk_bound, clk, arst_n, state_q == ST_FETCH, idx_q < walk_len)
	// a loaded result is presented next cycle
	`MSTL_ASSERT_NXT(a_rsp_load, clk, arst_n, rsp_load, rsp_valid_q)
	// only lookups end as found
	`MSTL_ASSERT_IMP(a_found_lookup, clk, arst_n, state_q == ST_FINISH && found_q, req_q.func == FUNC_ADDR || req_q.func == FUNC_INDEX)

endmodule

// ----- src/memory_segment_table_lookup_top.sv -----
// Sequence for an accepted item: a write, an unused code or an empty walk goes straight to the
// finish state; an address lookup walks fetch, bound and check per entry and, on a match, runs a
// 16-step divide and a multiply-add; an index lookup walks fetch and bound per entry.
// One item is in work at a time on one shared multiply-add/divide-step unit; the next item is
// accepted from the edge after the result is loaded, and a stalled result holds the sequencer.
// Reset clears the sequencer, output valid and entries_in_use; table entries are unset.
// Top level of the memory segment table lookup block with its configuration register.
// Depends on mstl_pkg, mstl_table, mstl_alu and mstl_ctrl.
module memory_segment_table_lookup_top import mstl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req_item,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic pready
);

	localparam logic [CFG_ADDR_W-1:0] EIU_ADDR = CFG_ADDR_W'(4 * REG_ENTRIES_IN_USE);

	logic [EIU_W-1:0] eiu_q;
	tbl_wr_t tbl_wr;
	logic tbl_rd_en;
	logic [IDX_W-1:0] tbl_rd_addr;
	entry_t tbl_rd_entry;
	alu_cmd_t alu_cmd;
	alu_out_t alu_out;

	// configuration register transfer
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == EIU_ADDR) begin
			eiu_q <= pwdata[EIU_W-1:0];
		end
	end

	assign prdata = (paddr == EIU_ADDR) ? CFG_DATA_W'(eiu_q) : '0;

	mstl_table u_table (
		.clk(clk),
		.wr(tbl_wr),
		.rd_en(tbl_rd_en),
		.rd_addr(tbl_rd_addr),
		.rd_entry(tbl_rd_entry)
	);

	mstl_alu u_alu (
		.clk(clk),
		.cmd(alu_cmd),
		.result(alu_out)
	);

	mstl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.entries_in_use(eiu_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item),
		.tbl_wr(tbl_wr),
		.tbl_rd_en(tbl_rd_en),
		.tbl_rd_addr(tbl_rd_addr),
		.tbl_rd_entry(tbl_rd_entry),
		.alu_cmd(alu_cmd),
		.alu_out(alu_out)
	);

endmodule
